// ===== hdl/nsd_pkg.sv =====
// Package for the netstring request deframer: result kinds, abort codes,
// register indexes, reset values and the configuration struct.
// No dependencies; every other file of the block uses it by scoped names.
package nsd_pkg;

    localparam int LEN_W = 31;

    // Result kinds.
    localparam logic [2:0] KIND_MSG   = 3'd0;
    localparam logic [2:0] KIND_SND   = 3'd1;
    localparam logic [2:0] KIND_RCP   = 3'd2;
    localparam logic [2:0] KIND_END   = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;
    localparam logic [2:0] KIND_ABORT = 3'd5;

    // Abort causes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PREFIX_BUDGET = 2'd0;
    localparam logic [1:0] CFG_LENGTH_GUARD  = 2'd1;
    localparam logic [1:0] CFG_FIELD_LIMIT   = 2'd2;

    // Register reset values.
    localparam logic [7:0]       PREFIX_BUDGET_RST = 8'd100;
    localparam logic [LEN_W-1:0] LENGTH_GUARD_RST  = 31'd200000000;
    localparam logic [15:0]      FIELD_LIMIT_RST   = 16'd1000;

    // Characters of the framing.
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0]       prefix_budget;
        logic [LEN_W-1:0] length_guard;
        logic [15:0]      field_limit;
    } cfg_t;

endpackage

// ===== hdl/netstring_request_deframer.sv =====
// Top level of the netstring request deframer: input register, configuration
// registers and the parser stage.
// Depends on nsd_pkg and nsd_core.
//
// Usage: request bytes enter one item per in_valid/in_ready handshake on
// in_byte. The block walks the nested netstring layout (outer length, message,
// sender, recipients, closing comma) and emits at most one result item per
// input byte on the out_valid/out_ready channel: a passed message, sender or
// recipient byte, a field end with its validity flag, request done, or an
// abort with its cause. Length digits, colons and the message comma give no result.
// A result is registered: an accepted byte is first loaded into the input
// register, the parser logic works on it there, and the result register is
// loaded when the parser stage steps.
// Throughput is one byte per cycle while results are taken; the parser updates
// its counters and compares combinationally; a length digit is one shift-add.
// When the receiver stalls, the result register holds its item, the input
// register fills behind it, and in_ready falls only when both are occupied.
// Reset clears both valid flags and puts the parser at the outer length with
// the default budget and limits; after request done or an abort the parser
// returns to that start state and reloads its budget from prefix_budget.
// The configuration channel is always ready and should be written only while
// the block is idle.
module netstring_request_deframer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               in_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               kind,
    output logic [7:0]               data,
    output logic                     field_ok,
    output logic [1:0]               error_code,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [nsd_pkg::LEN_W-1:0] cfg_data
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          step;
    nsd_pkg::cfg_t cfg_reg;

    // The parser stage advances whenever it holds a byte and its result
    // slot is free or being drained this cycle.
    assign step     = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
    end

    // Configuration registers; writes to unlisted indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prefix_budget <= nsd_pkg::PREFIX_BUDGET_RST;
            cfg_reg.length_guard  <= nsd_pkg::LENGTH_GUARD_RST;
            cfg_reg.field_limit   <= nsd_pkg::FIELD_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                nsd_pkg::CFG_PREFIX_BUDGET:
                begin
                    cfg_reg.prefix_budget <= cfg_data[7:0];
                end
                nsd_pkg::CFG_LENGTH_GUARD:
                begin
                    cfg_reg.length_guard <= cfg_data;
                end
                nsd_pkg::CFG_FIELD_LIMIT:
                begin
                    cfg_reg.field_limit <= cfg_data[15:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    nsd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .in_byte    (in_byte_reg),
        .cfg        (cfg_reg),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .kind       (kind),
        .data       (data),
        .field_ok   (field_ok),
        .error_code (error_code)
    );

endmodule

// ===== hdl/nsd_core.sv =====
// Parser stage of the netstring request deframer: the framing state machine
// and the result register with its valid flag.
// Depends on nsd_pkg.
module nsd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    input  nsd_pkg::cfg_t     cfg,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [2:0]        kind,
    output logic [7:0]        data,
    output logic              field_ok,
    output logic [1:0]        error_code
);

    typedef enum logic [2:0] {
        PH_OUTER_LEN,
        PH_MSG_LEN,
        PH_MSG_BODY,
        PH_MSG_COMMA,
        PH_FIELD_LEN,
        PH_FIELD_BODY,
        PH_FIELD_COMMA,
        PH_FINAL_COMMA
    } phase_t;

    typedef enum logic [1:0] {
        LEN_MORE,
        LEN_DONE,
        LEN_BAD,
        LEN_OVF
    } len_res_t;

    localparam int LW = nsd_pkg::LEN_W;

    phase_t          phase_reg, phase_next;
    logic [LW-1:0]   acc_reg, acc_next;
    logic [LW-1:0]   budget_reg, budget_next;
    logic [LW-1:0]   body_reg, body_next;
    logic            ftl_reg, ftl_next;
    logic            nul_reg, nul_next;
    logic            allok_reg, allok_next;
    logic            inrcp_reg, inrcp_next;

    logic            out_valid_reg;
    logic [2:0]      kind_reg;
    logic [7:0]      data_reg;
    logic            ok_reg;
    logic [1:0]      err_reg;

    logic            res_valid;
    logic [2:0]      res_kind;
    logic [7:0]      res_data;
    logic            res_ok;
    logic [1:0]      res_err;
    logic            restart;

    logic            is_digit;
    logic [3:0]      digit;
    logic [LW+3:0]   prod;
    len_res_t        len_res;
    logic [LW-1:0]   budget_dec;
    logic [LW-1:0]   body_dec;
    logic            field_good;

    // One length digit: acc * 10 + digit, built from two shifts.
    assign is_digit = (in_byte >= nsd_pkg::CHAR_ZERO) && (in_byte <= nsd_pkg::CHAR_NINE);
    assign digit    = 4'(in_byte - nsd_pkg::CHAR_ZERO);
    assign prod     = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {{LW{1'b0}}, digit};

    always_comb
    begin
        if (in_byte == nsd_pkg::CHAR_COLON) begin
            len_res = LEN_DONE;
        end else if (acc_reg > cfg.length_guard) begin
            len_res = LEN_OVF;
        end else if (!is_digit) begin
            len_res = LEN_BAD;
        end else if (|prod[LW+3:LW]) begin
            len_res = LEN_OVF;
        end else begin
            len_res = LEN_MORE;
        end
    end

    assign budget_dec = budget_reg - LW'(1);
    assign body_dec   = body_reg - LW'(1);
    assign field_good = !ftl_reg && !nul_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        budget_next = budget_reg;
        body_next   = body_reg;
        ftl_next    = ftl_reg;
        nul_next    = nul_reg;
        allok_next  = allok_reg;
        inrcp_next  = inrcp_reg;
        res_valid   = 1'b0;
        res_kind    = nsd_pkg::KIND_MSG;
        res_data    = 8'd0;
        res_ok      = 1'b0;
        res_err     = nsd_pkg::ERR_NONE;
        restart     = 1'b0;

        if (phase_reg != PH_FINAL_COMMA && budget_reg == '0) begin
            res_valid = 1'b1;
            res_kind  = nsd_pkg::KIND_ABORT;
            res_err   = nsd_pkg::ERR_MALFORMED;
            restart   = 1'b1;
        end else begin
            if (phase_reg != PH_FINAL_COMMA) begin
                budget_next = budget_dec;
            end
            case (phase_reg)
                PH_OUTER_LEN, PH_MSG_LEN, PH_FIELD_LEN:
                begin
                    case (len_res)
                        LEN_MORE:
                        begin
                            acc_next = prod[LW-1:0];
                        end
                        LEN_DONE:
                        begin
                            acc_next = '0;
                            if (phase_reg == PH_OUTER_LEN) begin
                                // The outer length becomes the body budget.
                                budget_next = acc_reg;
                                phase_next  = PH_MSG_LEN;
                            end else begin
                                body_next = acc_reg;
                                if (phase_reg == PH_FIELD_LEN) begin
                                    ftl_next   = acc_reg >= LW'(cfg.field_limit);
                                    nul_next   = 1'b0;
                                    phase_next = (acc_reg != '0) ? PH_FIELD_BODY
                                                                 : PH_FIELD_COMMA;
                                end else begin
                                    phase_next = (acc_reg != '0) ? PH_MSG_BODY
                                                                 : PH_MSG_COMMA;
                                end
                            end
                        end
                        LEN_BAD:
                        begin
                            res_valid = 1'b1;
                            res_kind  = nsd_pkg::KIND_ABORT;
                            res_err   = nsd_pkg::ERR_MALFORMED;
                            restart   = 1'b1;
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                            res_kind  = nsd_pkg::KIND_ABORT;
                            res_err   = nsd_pkg::ERR_OVERFLOW;
                            restart   = 1'b1;
                        end
                    endcase
                end
                PH_MSG_BODY:
                begin
                    body_next = body_dec;
                    if (body_dec == '0) begin
                        phase_next = PH_MSG_COMMA;
                    end
                    res_valid = 1'b1;
                    res_kind  = nsd_pkg::KIND_MSG;
                    res_data  = in_byte;
                end
                PH_MSG_COMMA:
                begin
                    if (in_byte != nsd_pkg::CHAR_COMMA) begin
                        res_valid = 1'b1;
                        res_kind  = nsd_pkg::KIND_ABORT;
                        res_err   = nsd_pkg::ERR_MALFORMED;
                        restart   = 1'b1;
                    end else begin
                        phase_next = PH_FIELD_LEN;
                        acc_next   = '0;
                    end
                end
                PH_FIELD_BODY:
                begin
                    body_next = body_dec;
                    if (body_dec == '0) begin
                        phase_next = PH_FIELD_COMMA;
                    end
                    if (in_byte == 8'd0) begin
                        nul_next = 1'b1;
                    end
                    // Bytes of a too-long field are swallowed.
                    if (!ftl_reg) begin
                        res_valid = 1'b1;
                        res_kind  = inrcp_reg ? nsd_pkg::KIND_RCP : nsd_pkg::KIND_SND;
                        res_data  = in_byte;
                    end
                end
                PH_FIELD_COMMA:
                begin
                    if (in_byte != nsd_pkg::CHAR_COMMA) begin
                        res_valid = 1'b1;
                        res_kind  = nsd_pkg::KIND_ABORT;
                        res_err   = nsd_pkg::ERR_MALFORMED;
                        restart   = 1'b1;
                    end else begin
                        if (!field_good) begin
                            allok_next = 1'b0;
                        end
                        inrcp_next = 1'b1;
                        ftl_next   = 1'b0;
                        nul_next   = 1'b0;
                        acc_next   = '0;
                        phase_next = (budget_dec != '0) ? PH_FIELD_LEN : PH_FINAL_COMMA;
                        res_valid  = 1'b1;
                        res_kind   = nsd_pkg::KIND_END;
                        res_ok     = field_good;
                    end
                end
                PH_FINAL_COMMA:
                begin
                    res_valid = 1'b1;
                    restart   = 1'b1;
                    if (in_byte != nsd_pkg::CHAR_COMMA) begin
                        res_kind = nsd_pkg::KIND_ABORT;
                        res_err  = nsd_pkg::ERR_MALFORMED;
                    end else begin
                        res_kind = nsd_pkg::KIND_DONE;
                        res_ok   = allok_reg;
                    end
                end
                default:
                begin
                    restart = 1'b1;
                end
            endcase
        end

        if (restart) begin
            phase_next  = PH_OUTER_LEN;
            acc_next    = '0;
            budget_next = LW'(cfg.prefix_budget);
            body_next   = '0;
            ftl_next    = 1'b0;
            nul_next    = 1'b0;
            allok_next  = 1'b1;
            inrcp_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_OUTER_LEN;
            acc_reg       <= '0;
            budget_reg    <= LW'(nsd_pkg::PREFIX_BUDGET_RST);
            body_reg      <= '0;
            ftl_reg       <= 1'b0;
            nul_reg       <= 1'b0;
            allok_reg     <= 1'b1;
            inrcp_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                phase_reg     <= phase_next;
                acc_reg       <= acc_next;
                budget_reg    <= budget_next;
                body_reg      <= body_next;
                ftl_reg       <= ftl_next;
                nul_reg       <= nul_next;
                allok_reg     <= allok_next;
                inrcp_reg     <= inrcp_next;
                out_valid_reg <= res_valid;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (step && res_valid) begin
            kind_reg <= res_kind;
            data_reg <= res_data;
            ok_reg   <= res_ok;
            err_reg  <= res_err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign data       = data_reg;
    assign field_ok   = ok_reg;
    assign error_code = err_reg;

endmodule

// ===== hdl/nsd_checker.sv =====
// Port-level checks for the netstring request deframer, bound to the top level.
// Depends on nsd_pkg and netstring_request_deframer.
module nsd_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [2:0]                kind,
    input  logic [7:0]                data,
    input  logic                      field_ok,
    input  logic [1:0]                error_code
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({kind, data, field_ok, error_code}))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= nsd_pkg::KIND_ABORT)
        else $error("result kind out of range");

    a_abort_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == nsd_pkg::KIND_ABORT) ==
                       (error_code == nsd_pkg::ERR_MALFORMED ||
                        error_code == nsd_pkg::ERR_OVERFLOW)))
        else $error("abort code does not match result kind");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == nsd_pkg::KIND_END || kind == nsd_pkg::KIND_DONE ||
                      kind == nsd_pkg::KIND_ABORT) |-> data == 8'd0)
        else $error("data nonzero on a control result");

    a_ok_only_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_ok |-> kind == nsd_pkg::KIND_END || kind == nsd_pkg::KIND_DONE)
        else $error("field_ok set on a result that is not an end");

endmodule

bind netstring_request_deframer nsd_checker u_nsd_checker (.*);
